// ===== src/mmt_pkg.sv =====
// Shared types and constants of the int8 matrix-multiply tile.
`timescale 1ns / 1ps
`default_nettype none
package mmt_pkg;

  localparam int ELEM_W = 8;
  localparam int PROD_W = 16;
  localparam int ACC_W  = 32;
  localparam int IDX_W  = 2;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic step;   // input item accepted
    logic last;   // that item ends the reduction
    logic shift;  // drain chain advances one place
  } cell_ctrl_t;

  // Drain sequencer status.
  typedef struct packed {
    logic valid;  // a sum is at the head of the chain
    logic last;   // head holds the final sum of the tile
    logic idle;   // chain can take a new tile this cycle
  } drain_stat_t;

endpackage
`default_nettype wire

// ===== src/mmt_in_if.sv =====
// Input channel: one reduction step of weights and activations per item.
`timescale 1ns / 1ps
`default_nettype none
interface mmt_in_if #(
  parameter int ROWS = 4,
  parameter int COLS = 4
);
  logic                                valid;
  logic                                ready;
  logic [ROWS*mmt_pkg::ELEM_W-1:0]     weight_row;
  logic [COLS*mmt_pkg::ELEM_W-1:0]     act_col;
  logic                                last_step;

  modport source (output valid, weight_row, act_col, last_step, input ready);
  modport sink   (input valid, weight_row, act_col, last_step, output ready);
endinterface
`default_nettype wire

// ===== src/mmt_out_if.sv =====
// Output channel: one tile sum per item.
`timescale 1ns / 1ps
`default_nettype none
interface mmt_out_if;
  logic          valid;
  logic          ready;
  mmt_pkg::idx_t out_row;
  mmt_pkg::idx_t out_col;
  mmt_pkg::acc_t dot_sum;
  logic          last_result;

  modport source (output valid, out_row, out_col, dot_sum, last_result, input ready);
  modport sink   (input valid, out_row, out_col, dot_sum, last_result, output ready);
endinterface
`default_nettype wire

// ===== src/mmt_cell.sv =====
// One multiply-accumulate cell with its stage of the drain chain.
`timescale 1ns / 1ps
`default_nettype none
module mmt_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mmt_pkg::cell_ctrl_t ctrl,
  input  wire mmt_pkg::elem_t      w,
  input  wire mmt_pkg::elem_t      a,
  input  wire mmt_pkg::acc_t       drain_in,
  output      mmt_pkg::acc_t       drain_out
);

  mmt_pkg::prod_t prod;
  mmt_pkg::acc_t  sum;
  mmt_pkg::acc_t  acc;
  mmt_pkg::acc_t  shadow;

  assign prod = w * a;
  assign sum  = acc + mmt_pkg::ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.step) begin
      acc <= ctrl.last ? '0 : sum;
    end
  end

  // load wins over shift: a new tile enters as the old one leaves
  always_ff @(posedge clk) begin
    if (ctrl.step && ctrl.last) begin
      shadow <= sum;
    end else if (ctrl.shift) begin
      shadow <= drain_in;
    end
  end

  assign drain_out = shadow;

endmodule
`default_nettype wire

// ===== src/mmt_drain.sv =====
// Drain sequencer: counts sums out of the chain and tracks their row and column.
`timescale 1ns / 1ps
`default_nettype none
module mmt_drain #(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire logic                 pop,
  output      mmt_pkg::drain_stat_t stat,
  output      mmt_pkg::idx_t        row,
  output      mmt_pkg::idx_t        col
);

  localparam int NUM = ROWS * COLS;
  localparam int CW  = $clog2(NUM + 1);
  localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LW  = (COLS > 1) ? $clog2(COLS) : 1;

  logic [CW-1:0] cnt;
  logic [RW-1:0] row_idx;
  logic [LW-1:0] col_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      row_idx <= '0;
      col_idx <= '0;
    end else if (load) begin
      cnt     <= CW'(NUM);
      row_idx <= '0;
      col_idx <= '0;
    end else if (pop) begin
      cnt <= cnt - 1'b1;
      if (col_idx == LW'(COLS - 1)) begin
        col_idx <= '0;
        row_idx <= row_idx + 1'b1;
      end else begin
        col_idx <= col_idx + 1'b1;
      end
    end
  end

  assign stat.valid = (cnt != '0);
  assign stat.last  = (cnt == CW'(1));
  assign stat.idle  = (cnt == '0) || ((cnt == CW'(1)) && pop);
  assign row        = mmt_pkg::IDX_W'(row_idx);
  assign col        = mmt_pkg::IDX_W'(col_idx);

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(NUM)) else $error("drain count out of range");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    stat.last |-> (row_idx == RW'(ROWS - 1)) && (col_idx == LW'(COLS - 1)))
    else $error("final sum not at last row and column");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    load |-> stat.idle) else $error("tile loaded over undrained sums");

  a_empty_after: assert property (@(posedge clk) disable iff (rst)
    pop && stat.last && !load |=> !stat.valid)
    else $error("chain not empty after final sum");

endmodule
`default_nettype wire

// ===== src/int8_matmul_tile_4x4.sv =====
// Top level of the output-stationary int8 matrix-multiply tile.
`timescale 1ns / 1ps
`default_nettype none
// Output-stationary TILE_ROWS x TILE_COLS int8 GEMM tile. Each input item is one
// reduction step; every cell multiplies its row weight by its column activation
// and adds the product into a wrapping 32-bit accumulator, so one item is taken
// per clock. On the item flagged last_step the sums are copied into a drain chain
// that runs through the cells and the accumulators restart from zero; the chain
// shifts one sum per output item toward cell (0,0), giving row-major order with
// last_result on the final sum. A last_step item waits until the final sum of the
// previous tile is taken, and can be accepted in the same cycle as that sum.
// Results appear in the cycle after the last step is accepted. out_row and
// out_col carry the low two bits of the index.
module int8_matmul_tile_4x4 #(
  parameter int TILE_ROWS = 4,
  parameter int TILE_COLS = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mmt_in_if.sink      in_ch,
  mmt_out_if.source   out_ch
);

  localparam int NUM = TILE_ROWS * TILE_COLS;

  mmt_pkg::cell_ctrl_t  ctrl;
  mmt_pkg::drain_stat_t stat;
  mmt_pkg::acc_t        chain [NUM+1];
  logic                 accept;
  logic                 pop;

  assign in_ch.ready = !in_ch.last_step || stat.idle;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  assign ctrl.step  = accept;
  assign ctrl.last  = in_ch.last_step;
  assign ctrl.shift = pop;

  assign chain[NUM] = '0;

  for (genvar r = 0; r < TILE_ROWS; r++) begin : g_row
    for (genvar c = 0; c < TILE_COLS; c++) begin : g_col
      mmt_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .w         (in_ch.weight_row[r*mmt_pkg::ELEM_W +: mmt_pkg::ELEM_W]),
        .a         (in_ch.act_col[c*mmt_pkg::ELEM_W +: mmt_pkg::ELEM_W]),
        .drain_in  (chain[r*TILE_COLS + c + 1]),
        .drain_out (chain[r*TILE_COLS + c])
      );
    end
  end

  mmt_drain #(
    .ROWS (TILE_ROWS),
    .COLS (TILE_COLS)
  ) u_drain (
    .clk  (clk),
    .rst  (rst),
    .load (accept && in_ch.last_step),
    .pop  (pop),
    .stat (stat),
    .row  (out_ch.out_row),
    .col  (out_ch.out_col)
  );

  assign out_ch.valid       = stat.valid;
  assign out_ch.dot_sum     = chain[0];
  assign out_ch.last_result = stat.last;

  a_emit: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.last_step |=> out_ch.valid)
    else $error("no sum after final step");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready && !(accept && in_ch.last_step)
    |=> $stable(out_ch.dot_sum)) else $error("stalled sum changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ch.last_step |-> in_ch.ready) else $error("plain step stalled");

endmodule
`default_nettype wire
